>>> rtl/laplacian_3x3_rgba_filter_core_macros.svh
// Assertion macros used by the checker file of the filter core.
// They expect signals named clk and rst_n in the scope where they are used.
`ifndef LAPLACIAN_3X3_RGBA_FILTER_CORE_MACROS_SVH
`define LAPLACIAN_3X3_RGBA_FILTER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LAPF_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LAPF_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

>>> rtl/lapf_pkg.sv
`timescale 1ns / 1ps

package lapf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int CHANNELS   = 4;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int CHAN_W  = 8;
    localparam int LANES   = 4;
    localparam int PIX_W   = CHAN_W * LANES;
    localparam int WIN_N   = 9;
    localparam int HIST_N  = 6;

    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int APB_ADDR_W   = 4;
    localparam int APB_DATA_W   = 32;

    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MASK_SELECT  = 2'd2;

    localparam logic [CFG_WIDTH_W-1:0]  RST_IMAGE_WIDTH  = 11'd1024;
    localparam logic [CFG_HEIGHT_W-1:0] RST_IMAGE_HEIGHT = 13'd768;
    localparam logic                    RST_MASK_SELECT  = 1'b1;

    localparam logic [CHAN_W-1:0] OUT_OFFSET = 8'd128;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [PIX_W-1:0]  pixel_t;

    typedef struct packed {
        logic [7:0] chan0_in;
        logic [7:0] chan1_in;
        logic [7:0] chan2_in;
        logic [7:0] chan3_in;
    } pix_word_t;

    typedef struct packed {
        logic [7:0] chan0_out;
        logic [7:0] chan1_out;
        logic [7:0] chan2_out;
        logic [7:0] chan3_out;
        logic       frame_last;
    } res_word_t;

    // Window entry 3*column + row, column 0 is the oldest, row 0 is the top.
    typedef pixel_t [WIN_N-1:0] window_t;

    typedef chan_t [LANES-1:0] lane_bytes_t;

endpackage

>>> rtl/lapf_ram.sv
`timescale 1ns / 1ps

module lapf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/lapf_kernel.sv
`timescale 1ns / 1ps

module lapf_kernel
    import lapf_pkg::*;
(
    input  window_t     win,
    input  logic        mask_select,
    output lane_bytes_t lanes
);

    // Only the low eight bits of the sum survive, so all arithmetic wraps at eight bits.
    for (genvar c = 0; c < LANES; c++)
    begin : g_lane
        if (c < CHANNELS)
        begin : g_used
            chan_t ctr;
            chan_t edge_sum;
            chan_t corner_sum;

            always_comb
            begin
                ctr        = win[4][c*CHAN_W +: CHAN_W];
                edge_sum   = chan_t'(win[3][c*CHAN_W +: CHAN_W] + win[5][c*CHAN_W +: CHAN_W]
                                   + win[1][c*CHAN_W +: CHAN_W] + win[7][c*CHAN_W +: CHAN_W]);
                corner_sum = chan_t'(win[0][c*CHAN_W +: CHAN_W] + win[2][c*CHAN_W +: CHAN_W]
                                   + win[6][c*CHAN_W +: CHAN_W] + win[8][c*CHAN_W +: CHAN_W]);
                if (mask_select)
                begin
                    lanes[c] = chan_t'({ctr[CHAN_W-4:0], 3'b000} - edge_sum - corner_sum
                                       + OUT_OFFSET);
                end
                else
                begin
                    lanes[c] = chan_t'({ctr[CHAN_W-3:0], 2'b00} - edge_sum + OUT_OFFSET);
                end
            end
        end
        else
        begin : g_unused
            assign lanes[c] = '0;
        end
    end

endmodule

>>> rtl/laplacian_3x3_rgba_filter_core.sv
`timescale 1ns / 1ps

// Streaming 3x3 Laplacian filter for four-channel 8-bit pixels.
// Pixels enter in raster order on the pix channel, one word per pixel, and each
// interior pixel of the frame gives one filtered word on the res channel; the
// frame border gives none. A word moves when valid is high and stall is low.
// The result for the pixel one row up and one column left of an accepted pixel
// appears in the cycle after acceptance; one pixel is accepted every cycle
// while pix_stall is low. The rate is set by the combinational kernel between
// the window registers and the result register; the two line buffers are RAMs
// with one write and one read port each, read ahead at the next column.
// When the receiver stalls, the result word holds, and pix_stall rises only
// for a pixel that would produce a new result; border pixels still flow.
// Reset clears the position counters, the column window and the result valid,
// and sets width 1024, height 768 and the eight-neighbor mask. The line
// buffers are not cleared; their contents are never used before being written.
// The APB port sets width, height and mask; write it only while idle.
module laplacian_3x3_rgba_filter_core
    import lapf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  pix_valid,
    output logic                  pix_stall,
    input  pix_word_t             pix_word,
    output logic                  res_valid,
    input  logic                  res_stall,
    output res_word_t             res_word
);

    logic [CFG_WIDTH_W-1:0]  width_reg;
    logic [CFG_HEIGHT_W-1:0] height_reg;
    logic                    mask_reg;

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    pixel_t           hist_reg [HIST_N];

    logic      res_valid_reg;
    logic      res_valid_next;
    res_word_t res_word_reg;

    logic             cfg_write;
    logic [1:0]       cfg_index;
    logic [COL_W-1:0] col_last;
    logic [ROW_W-1:0] row_last;
    logic             row_end;
    logic             frame_end;
    logic             interior;
    logic             pix_accept;
    pixel_t           pix;
    pixel_t           upper_rd;
    pixel_t           middle_rd;
    window_t          win;
    lane_bytes_t      lanes;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_IMAGE_WIDTH;
            height_reg <= RST_IMAGE_HEIGHT;
            mask_reg   <= RST_MASK_SELECT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[CFG_WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[CFG_HEIGHT_W-1:0];
                REG_MASK_SELECT:  mask_reg   <= pwdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(height_reg);
            REG_MASK_SELECT:  prdata = APB_DATA_W'(mask_reg);
            default:          prdata = '0;
        endcase
    end

    // The frame size is saturated to the supported range before use.
    always_comb
    begin
        if (32'(width_reg) < 32'd3)
        begin
            col_last = COL_W'(2);
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            col_last = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            col_last = COL_W'(32'(width_reg) - 32'd1);
        end

        if (32'(height_reg) < 32'd3)
        begin
            row_last = ROW_W'(2);
        end
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
        begin
            row_last = ROW_W'(MAX_HEIGHT - 1);
        end
        else
        begin
            row_last = ROW_W'(32'(height_reg) - 32'd1);
        end
    end

    assign row_end    = col_reg >= col_last;
    assign frame_end  = row_end && (row_reg >= row_last);
    assign interior   = (col_reg >= COL_W'(2)) && (row_reg >= ROW_W'(2));
    assign pix_stall  = res_valid_reg && res_stall && interior;
    assign pix_accept = pix_valid && !pix_stall;
    assign pix        = {pix_word.chan3_in, pix_word.chan2_in,
                         pix_word.chan1_in, pix_word.chan0_in};

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (pix_accept)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = frame_end ? '0 : ROW_W'(row_reg + 1'b1);
            end
            else
            begin
                col_next = COL_W'(col_reg + 1'b1);
            end
        end
    end

    // The line buffers are read at the next column so that the registered
    // read data lines up with the pixel that arrives there.
    lapf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_upper_line (
        .clk   (clk),
        .we    (pix_accept),
        .waddr (col_reg),
        .wdata (middle_rd),
        .raddr (col_next),
        .rdata (upper_rd)
    );

    lapf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_middle_line (
        .clk   (clk),
        .we    (pix_accept),
        .waddr (col_reg),
        .wdata (pix),
        .raddr (col_next),
        .rdata (middle_rd)
    );

    always_comb
    begin
        for (int k = 0; k < HIST_N; k++)
        begin
            win[k] = hist_reg[k];
        end
        win[6] = upper_rd;
        win[7] = middle_rd;
        win[8] = pix;
    end

    lapf_kernel u_kernel (
        .win         (win),
        .mask_select (mask_reg),
        .lanes       (lanes)
    );

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (pix_accept && interior)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            res_valid_reg <= 1'b0;
            for (int k = 0; k < HIST_N; k++)
            begin
                hist_reg[k] <= '0;
            end
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            res_valid_reg <= res_valid_next;
            if (pix_accept)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    hist_reg[k]     <= hist_reg[3 + k];
                    hist_reg[3 + k] <= win[6 + k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_accept && interior)
        begin
            res_word_reg.chan0_out  <= lanes[0];
            res_word_reg.chan1_out  <= lanes[1];
            res_word_reg.chan2_out  <= lanes[2];
            res_word_reg.chan3_out  <= lanes[3];
            res_word_reg.frame_last <= frame_end;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

endmodule

>>> rtl/lapf_checker.sv
`timescale 1ns / 1ps
`include "laplacian_3x3_rgba_filter_core_macros.svh"

module lapf_checker
    import lapf_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      pix_valid,
    input logic      pix_stall,
    input logic      res_valid,
    input logic      res_stall,
    input res_word_t res_word
);

    // A stalled result word stays valid and unchanged.
    `LAPF_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res_word))

    // The input side is held back only by a stalled result.
    `LAPF_ASSERT_SAME(a_stall_cause, !(res_valid && res_stall), !pix_stall)

    // A new result word appears only after a pixel was accepted.
    `LAPF_ASSERT_SAME(a_res_source, $rose(res_valid), $past(pix_valid && !pix_stall))

    // A result taken while no pixel is accepted is dropped, never repeated.
    `LAPF_ASSERT_NEXT(a_no_repeat, res_valid && !res_stall && !(pix_valid && !pix_stall), !res_valid)

endmodule

bind laplacian_3x3_rgba_filter_core lapf_checker u_lapf_checker (.*);
